// File: sv/framed_word_stream_decoder_unit_defines.svh
// Assertion macros used by fwsd_decode of the framed word stream decoder.
`ifndef FRAMED_WORD_STREAM_DECODER_UNIT_DEFINES_SVH
`define FRAMED_WORD_STREAM_DECODER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FWSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FWSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/fwsd_pkg.sv
// Types and constants of the framed word stream decoder.
package fwsd_pkg;

  typedef enum logic [2:0] {
    ST_BUSY     = 3'd0,
    ST_COMMAND  = 3'd1,
    ST_LEAD_ERR = 3'd2,
    ST_DATA_ERR = 3'd3,
    ST_END_ERR  = 3'd4,
    ST_SUM_ERR  = 3'd5,
    ST_DONE     = 3'd6
  } fwsd_status_t;

  // Byte kind from bits 7:6.
  localparam logic [1:0] KIND_LEAD = 2'b11;
  localparam logic [1:0] KIND_END  = 2'b10;

  localparam logic [2:0]  CNT_LONG     = 3'd7;
  localparam logic [2:0]  BLOCKS_LONG  = 3'd5;
  localparam logic [15:0] INV_PATTERN  = 16'hFFFF;

  typedef struct packed {
    fwsd_status_t status;
    logic [6:0]   address;
    logic [31:0]  word;
  } fwsd_result_t;

endpackage

// File: sv/framed_word_stream_decoder_unit.sv
// Top level of the framed word stream decoder.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  in_rx_byte[7:0]
//   out_     output     out_valid/out_stall out_status[2:0], out_address[6:0], out_word[31:0]
//   cfg_     input      cfg_valid/cfg_ready cfg_check_inverse
//
// One item is accepted per cycle while in_stall is low; each item gives exactly one result item.
// Each item passes an input register, the decode logic, then a result register.
// A stalled result holds; the input register still fills once, then in_stall rises.
// Reset is synchronous and clears the frame state and check_inverse.
// Configuration writes are always taken (cfg_ready is tied high).
module framed_word_stream_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [6:0]  out_address,
  output logic [31:0] out_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_check_inverse
);

  logic                   check_inverse_r;
  logic                   s1_valid;
  logic [7:0]             s1_byte;
  logic                   advance;
  fwsd_pkg::fwsd_result_t result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_inverse_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      check_inverse_r <= cfg_check_inverse;
    end
  end

  fwsd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .advance    (advance),
    .s1_valid   (s1_valid),
    .s1_byte    (s1_byte)
  );

  fwsd_decode u_dec (
    .clk           (clk),
    .rst_n         (rst_n),
    .check_inverse (check_inverse_r),
    .s1_valid      (s1_valid),
    .s1_byte       (s1_byte),
    .advance       (advance),
    .result        (result)
  );

  fwsd_out_stage u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .s1_valid    (s1_valid),
    .result      (result),
    .advance     (advance),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (out_status),
    .out_address (out_address),
    .out_word    (out_word)
  );

endmodule

// File: sv/fwsd_in_stage.sv
// Input register stage of the framed word stream decoder.
module fwsd_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       advance,
  output logic       s1_valid,
  output logic [7:0] s1_byte
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;

  // The register may refill in the same cycle its item moves on.
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_byte  = s1_byte_r;

endmodule

// File: sv/fwsd_decode.sv
// Frame state and per-byte decode logic of the framed word stream decoder.
`include "framed_word_stream_decoder_unit_defines.svh"

module fwsd_decode (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  check_inverse,
  input  logic                  s1_valid,
  input  logic [7:0]            s1_byte,
  input  logic                  advance,
  output fwsd_pkg::fwsd_result_t result
);

  logic [2:0]  blocks_left_r, blocks_left_nxt;
  logic [31:0] work_word_r, work_word_nxt;
  logic        clear_pending_r, clear_pending_nxt;
  logic [2:0]  bl_eff;
  logic [2:0]  cnt;
  logic        step;

  assign step = s1_valid && advance;
  assign cnt  = s1_byte[5:3];

  always_comb begin
    bl_eff          = clear_pending_r ? 3'd0 : blocks_left_r;
    blocks_left_nxt = bl_eff;
    work_word_nxt   = work_word_r;
    result.status   = fwsd_pkg::ST_BUSY;
    result.address  = 7'd0;
    result.word     = 32'd0;

    case (s1_byte[7:6])
      fwsd_pkg::KIND_LEAD: begin
        if (cnt <= 3'd1) begin
          result.status = fwsd_pkg::ST_COMMAND;
        end else begin
          // A new lead always starts a frame; one already open is reported.
          if (bl_eff != 3'd0) begin
            result.status = fwsd_pkg::ST_LEAD_ERR;
          end
          if (cnt == fwsd_pkg::CNT_LONG) begin
            work_word_nxt   = {28'd0, s1_byte[3:0]};
            blocks_left_nxt = fwsd_pkg::BLOCKS_LONG;
          end else begin
            work_word_nxt   = {29'd0, s1_byte[2:0]};
            blocks_left_nxt = cnt - 3'd1;
          end
        end
      end
      fwsd_pkg::KIND_END: begin
        if (bl_eff == 3'd1) begin
          if (check_inverse &&
              ((work_word_r[15:0] ^ work_word_r[31:16]) != fwsd_pkg::INV_PATTERN)) begin
            result.status = fwsd_pkg::ST_SUM_ERR;
          end else begin
            result.status  = fwsd_pkg::ST_DONE;
            result.address = {1'b0, s1_byte[5:0]} + 7'd1;
            result.word    = work_word_r;
          end
        end else begin
          result.status = fwsd_pkg::ST_END_ERR;
        end
      end
      default: begin
        if (bl_eff >= 3'd2) begin
          blocks_left_nxt = bl_eff - 3'd1;
          work_word_nxt   = {work_word_r[24:0], s1_byte[6:0]};
        end else begin
          result.status = fwsd_pkg::ST_DATA_ERR;
        end
      end
    endcase

    clear_pending_nxt = (result.status != fwsd_pkg::ST_BUSY) &&
                        (result.status != fwsd_pkg::ST_LEAD_ERR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocks_left_r   <= 3'd0;
      work_word_r     <= 32'd0;
      clear_pending_r <= 1'b0;
    end else if (step) begin
      blocks_left_r   <= blocks_left_nxt;
      work_word_r     <= work_word_nxt;
      clear_pending_r <= clear_pending_nxt;
    end
  end

  `FWSD_ASSERT_NOW(a_blocks_range, 1'b1, blocks_left_r <= fwsd_pkg::BLOCKS_LONG,
    "blocks_left exceeds longest frame")
  `FWSD_ASSERT_NOW(a_done_addr, step && result.status == fwsd_pkg::ST_DONE,
    result.address != 7'd0, "finished frame with zero address")
  `FWSD_ASSERT_NOW(a_word_zero, step && result.status != fwsd_pkg::ST_DONE,
    result.word == 32'd0 && result.address == 7'd0, "payload on unfinished result")
  `FWSD_ASSERT_NEXT(a_clear_sched, step && clear_pending_nxt, clear_pending_r,
    "final result did not schedule a clear")

endmodule

// File: sv/fwsd_out_stage.sv
// Result register stage of the framed word stream decoder.
module fwsd_out_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  s1_valid,
  input  fwsd_pkg::fwsd_result_t result,
  output logic                  advance,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_status,
  output logic [6:0]            out_address,
  output logic [31:0]           out_word
);

  logic                   out_valid_r;
  fwsd_pkg::fwsd_result_t result_r;

  // The result register takes a new item when empty or being emptied.
  assign advance = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      result_r <= result;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = result_r.status;
  assign out_address = result_r.address;
  assign out_word    = result_r.word;

endmodule
